### rtl/core/cad_pkg.sv
// Shared constants and types for the complex add/multiply/divide unit.
// No dependencies; imported by the datapath and its port checker.
package cad_pkg;

  // Default operand format: signed Q8.8
  localparam int CAD_COMPONENT_WIDTH = 16;
  localparam int CAD_FRACTION_BITS   = 8;

  // Stages outside the one-bit-per-stage divider
  localparam int CAD_PIPE_EXTRA = 5;

  typedef logic [1:0] op_t;

  localparam op_t OP_ADD = 2'd0;
  localparam op_t OP_MUL = 2'd1;
  localparam op_t OP_DIV = 2'd2;

endpackage

### rtl/core/complex_add_multiply_divide.sv
// Complex add / multiply / divide unit, fully pipelined.
// Depends on cad_pkg (operation codes, default widths).
//
// Usage:
//   Input channel: drive in_operation and the operand parts with start high.
//   A transfer happens at every rising edge with start high and busy low;
//   busy is always low, so a new item may enter in every cycle.
//   Result channel: out_valid is high for exactly one cycle per item, with
//   out_res_re, out_res_im, out_overflow and out_divide_by_zero. The receiver
//   cannot stall; results come out in input order.
// Throughput: one item per cycle. The pipeline depth is set by the restoring
//   divider, which resolves one quotient bit per pipeline stage for both
//   result parts in parallel.
// Stages: operand capture, six multipliers, sum/difference and divisor
//   magnitude, sign/magnitude split with quotient range check, one stage per
//   quotient bit, then selection and saturation into the output registers.
//   Add and multiply items ride the same pipe untouched by the divider.
// Reset: synchronous on rst_n low; clears every valid bit, so nothing in
//   flight at reset is ever reported.
module complex_add_multiply_divide #(
  parameter int COMPONENT_WIDTH = cad_pkg::CAD_COMPONENT_WIDTH,
  parameter int FRACTION_BITS   = cad_pkg::CAD_FRACTION_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  cad_pkg::op_t                       in_operation,
  input  logic signed [COMPONENT_WIDTH-1:0]  in_a_re,
  input  logic signed [COMPONENT_WIDTH-1:0]  in_a_im,
  input  logic signed [COMPONENT_WIDTH-1:0]  in_b_re,
  input  logic signed [COMPONENT_WIDTH-1:0]  in_b_im,
  output logic                               out_valid,
  output logic signed [COMPONENT_WIDTH-1:0]  out_res_re,
  output logic signed [COMPONENT_WIDTH-1:0]  out_res_im,
  output logic                               out_overflow,
  output logic                               out_divide_by_zero
);
  import cad_pkg::*;

  localparam int W  = COMPONENT_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int PW = 2 * W;          // product width
  localparam int SW = 2 * W + 1;      // signed sum of two products
  localparam int MW = 2 * W;          // magnitude / divisor width
  localparam int CW = 3 * W + F;      // divider remainder width

  localparam logic [MW-1:0] HALF   = MW'(1) << (W - 1);
  localparam logic [MW-1:0] BIGMAG = HALF + MW'(1);

  // Never stall the input
  assign busy = 1'b0;

  // ---------------- stage 1: operand capture ----------------
  logic                 v1_r;
  op_t                  op1_r;
  logic signed [W-1:0]  ar1_r, ai1_r, br1_r, bi1_r;

  // ---------------- stage 2: products ----------------
  logic                 v2_r;
  op_t                  op2_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, sq_r_r, sq_i_r;
  logic signed [W:0]    add_re_r, add_im_r;

  // ---------------- stage 3: sums ----------------
  logic                 v3_r;
  op_t                  op3_r;
  logic signed [SW-1:0] s_re_r, s_im_r;
  logic [MW-1:0]        den3_r;
  logic signed [SW-1:0] s_re_nxt, s_im_nxt;

  // ---------------- stage 4 and divider stages ----------------
  // Index 0 is the sign/magnitude stage, index j+1 follows quotient bit j.
  logic          dv_r    [0:W];
  op_t           dop_r   [0:W];
  logic          dneg_re_r [0:W];
  logic          dneg_im_r [0:W];
  logic          dbig_re_r [0:W];
  logic          dbig_im_r [0:W];
  logic          ddbz_r  [0:W];
  logic [MW-1:0] dden_r  [0:W];
  logic [CW-1:0] drem_re_r [0:W];
  logic [CW-1:0] drem_im_r [0:W];
  logic [W-1:0]  dq_re_r [0:W];
  logic [W-1:0]  dq_im_r [0:W];

  logic [SW-1:0] mag_re_full, mag_im_full;
  logic [MW-1:0] mag_re4, mag_im4;
  logic          is_div3;

  // Valid bits: the only state that reset clears
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int j = 0; j <= W; j++) begin
        dv_r[j] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      v1_r  <= start & ~busy;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      dv_r[0] <= v3_r;
      for (int j = 0; j < W; j++) begin
        dv_r[j+1] <= dv_r[j];
      end
      out_valid <= dv_r[W];
    end
  end

  // Stages 1 and 2: capture, then the six products and the plain sums
  always_ff @(posedge clk) begin
    op1_r <= in_operation;
    ar1_r <= in_a_re;
    ai1_r <= in_a_im;
    br1_r <= in_b_re;
    bi1_r <= in_b_im;

    op2_r    <= op1_r;
    p_rr_r   <= PW'(ar1_r) * PW'(br1_r);
    p_ii_r   <= PW'(ai1_r) * PW'(bi1_r);
    p_ir_r   <= PW'(ai1_r) * PW'(br1_r);
    p_ri_r   <= PW'(ar1_r) * PW'(bi1_r);
    sq_r_r   <= PW'(br1_r) * PW'(br1_r);
    sq_i_r   <= PW'(bi1_r) * PW'(bi1_r);
    add_re_r <= (W+1)'(ar1_r) + (W+1)'(br1_r);
    add_im_r <= (W+1)'(ai1_r) + (W+1)'(bi1_r);
  end

  // Stage 3: combine products per operation; divide uses the conjugate
  always_comb begin
    case (op2_r)
      OP_ADD: begin
        s_re_nxt = SW'(add_re_r);
        s_im_nxt = SW'(add_im_r);
      end
      OP_MUL: begin
        s_re_nxt = SW'(p_rr_r) - SW'(p_ii_r);
        s_im_nxt = SW'(p_ir_r) + SW'(p_ri_r);
      end
      OP_DIV: begin
        s_re_nxt = SW'(p_rr_r) + SW'(p_ii_r);
        s_im_nxt = SW'(p_ir_r) - SW'(p_ri_r);
      end
      default: begin
        s_re_nxt = '0;
        s_im_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op3_r  <= op2_r;
    s_re_r <= s_re_nxt;
    s_im_r <= s_im_nxt;
    den3_r <= MW'(unsigned'(sq_r_r)) + MW'(unsigned'(sq_i_r));
  end

  // Stage 4: sign and magnitude, scale the dividend, flag quotients that
  // cannot fit in W bits (they saturate whatever the low bits say)
  assign mag_re_full = s_re_r[SW-1] ? SW'(-s_re_r) : SW'(s_re_r);
  assign mag_im_full = s_im_r[SW-1] ? SW'(-s_im_r) : SW'(s_im_r);
  assign mag_re4     = mag_re_full[MW-1:0];
  assign mag_im4     = mag_im_full[MW-1:0];
  assign is_div3     = (op3_r == OP_DIV);

  always_ff @(posedge clk) begin
    dop_r[0]     <= op3_r;
    dneg_re_r[0] <= s_re_r[SW-1];
    dneg_im_r[0] <= s_im_r[SW-1];
    dden_r[0]    <= den3_r;
    ddbz_r[0]    <= is_div3 && (den3_r == '0);
    dbig_re_r[0] <= (CW'(mag_re4) << F) >= (CW'(den3_r) << W);
    dbig_im_r[0] <= (CW'(mag_im4) << F) >= (CW'(den3_r) << W);
    drem_re_r[0] <= is_div3 ? (CW'(mag_re4) << F) : CW'(mag_re4);
    drem_im_r[0] <= is_div3 ? (CW'(mag_im4) << F) : CW'(mag_im4);
    dq_re_r[0]   <= '0;
    dq_im_r[0]   <= '0;

    // Restoring division, one quotient bit per stage, MSB first.
    // Only divide items subtract; the rest carry their magnitude through.
    for (int j = 0; j < W; j++) begin
      dop_r[j+1]     <= dop_r[j];
      dneg_re_r[j+1] <= dneg_re_r[j];
      dneg_im_r[j+1] <= dneg_im_r[j];
      dbig_re_r[j+1] <= dbig_re_r[j];
      dbig_im_r[j+1] <= dbig_im_r[j];
      ddbz_r[j+1]    <= ddbz_r[j];
      dden_r[j+1]    <= dden_r[j];
      if ((dop_r[j] == OP_DIV) && (drem_re_r[j] >= (CW'(dden_r[j]) << (W - 1 - j)))) begin
        drem_re_r[j+1] <= drem_re_r[j] - (CW'(dden_r[j]) << (W - 1 - j));
        dq_re_r[j+1]   <= {dq_re_r[j][W-2:0], 1'b1};
      end else begin
        drem_re_r[j+1] <= drem_re_r[j];
        dq_re_r[j+1]   <= {dq_re_r[j][W-2:0], 1'b0};
      end
      if ((dop_r[j] == OP_DIV) && (drem_im_r[j] >= (CW'(dden_r[j]) << (W - 1 - j)))) begin
        drem_im_r[j+1] <= drem_im_r[j] - (CW'(dden_r[j]) << (W - 1 - j));
        dq_im_r[j+1]   <= {dq_im_r[j][W-2:0], 1'b1};
      end else begin
        drem_im_r[j+1] <= drem_im_r[j];
        dq_im_r[j+1]   <= {dq_im_r[j][W-2:0], 1'b0};
      end
    end
  end

  // Final stage: pick the magnitude, saturate, drive the output registers
  function automatic logic [MW-1:0] pick_mag(op_t op, logic [CW-1:0] rem,
                                             logic [W-1:0] q, logic big, logic dbz);
    logic [MW-1:0] m;
    m = rem[MW-1:0];
    case (op)
      OP_ADD:  pick_mag = m;
      OP_MUL:  pick_mag = m >> F;
      OP_DIV:  pick_mag = dbz ? '0 : (big ? BIGMAG : MW'(q));
      default: pick_mag = '0;
    endcase
  endfunction

  logic [MW-1:0] fmag_re, fmag_im;
  logic          fneg_re, fneg_im;
  logic          sat_re, sat_im;
  logic [W-1:0]  res_re_nxt, res_im_nxt;

  always_comb begin
    fmag_re = pick_mag(dop_r[W], drem_re_r[W], dq_re_r[W], dbig_re_r[W], ddbz_r[W]);
    fmag_im = pick_mag(dop_r[W], drem_im_r[W], dq_im_r[W], dbig_im_r[W], ddbz_r[W]);
    // A zero magnitude is never negative
    fneg_re = dneg_re_r[W] && (fmag_re != '0);
    fneg_im = dneg_im_r[W] && (fmag_im != '0);
    sat_re  = fneg_re ? (fmag_re > HALF) : (fmag_re > HALF - MW'(1));
    sat_im  = fneg_im ? (fmag_im > HALF) : (fmag_im > HALF - MW'(1));
    if (sat_re) begin
      res_re_nxt = fneg_re ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      res_re_nxt = fneg_re ? W'(-fmag_re) : W'(fmag_re);
    end
    if (sat_im) begin
      res_im_nxt = fneg_im ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      res_im_nxt = fneg_im ? W'(-fmag_im) : W'(fmag_im);
    end
  end

  always_ff @(posedge clk) begin
    out_res_re         <= res_re_nxt;
    out_res_im         <= res_im_nxt;
    out_overflow       <= sat_re | sat_im;
    out_divide_by_zero <= ddbz_r[W];
  end

endmodule

### rtl/core/cad_checker.sv
// Port-level checker for the complex arithmetic unit, bound to the top level.
// Depends on cad_pkg and complex_add_multiply_divide.
module cad_checker #(
  parameter int COMPONENT_WIDTH = cad_pkg::CAD_COMPONENT_WIDTH
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input cad_pkg::op_t                      in_operation,
  input logic                              out_valid,
  input logic signed [COMPONENT_WIDTH-1:0] out_res_re,
  input logic signed [COMPONENT_WIDTH-1:0] out_res_im,
  input logic                              out_overflow,
  input logic                              out_divide_by_zero
);
  import cad_pkg::*;

  localparam int LAT = COMPONENT_WIDTH + CAD_PIPE_EXTRA;
  localparam logic [COMPONENT_WIDTH-1:0] MAXV = {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
  localparam logic [COMPONENT_WIDTH-1:0] MINV = {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};

  // Every transfer in yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after input transfer");

  // Divide-by-zero only for divide items
  a_dbz_op: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation != OP_DIV) |-> ##LAT !out_divide_by_zero)
    else $error("divide_by_zero on non-divide item");

  // Zero divisor gives a clean zero result
  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |->
      (out_res_re == '0 && out_res_im == '0 && !out_overflow))
    else $error("divide_by_zero result not zero");

  // Overflow means some part sits at a limit
  a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |->
      (out_res_re == MAXV || out_res_re == MINV ||
       out_res_im == MAXV || out_res_im == MINV))
    else $error("overflow without saturated part");

endmodule

bind complex_add_multiply_divide cad_checker #(
  .COMPONENT_WIDTH(COMPONENT_WIDTH)
) u_cad_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_operation       (in_operation),
  .out_valid          (out_valid),
  .out_res_re         (out_res_re),
  .out_res_im         (out_res_im),
  .out_overflow       (out_overflow),
  .out_divide_by_zero (out_divide_by_zero)
);

### sim/tb.sv
// Self-checking testbench for complex_add_multiply_divide: directed and random items.
// Depends on cad_pkg and rtl/core/complex_add_multiply_divide.sv.
`timescale 1ns / 1ps

module tb;
  import cad_pkg::*;

  localparam int W = CAD_COMPONENT_WIDTH;
  localparam int F = CAD_FRACTION_BITS;
  localparam int LATENCY = W + CAD_PIPE_EXTRA;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam op_t OP_UNUSED = 2'd3;

  typedef struct packed {
    op_t           op;
    logic [W-1:0]  a_re, a_im, b_re, b_im;
  } operand_set_t;

  typedef struct packed {
    logic [W-1:0] re, im;
    logic         ovf, dbz;
  } complex_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  op_t in_operation = OP_ADD;
  logic signed [W-1:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic out_valid;
  logic signed [W-1:0] out_res_re, out_res_im;
  logic out_overflow, out_divide_by_zero;

  operand_set_t    pending_q[$];
  complex_result_t expected_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  bit stimulus_done = 1'b0;
  int op_count[4] = '{0, 0, 0, 0};
  int ovf_count = 0, dbz_count = 0;

  complex_add_multiply_divide uut (
    .clk, .rst_n, .start, .busy, .in_operation,
    .in_a_re, .in_a_im, .in_b_re, .in_b_im,
    .out_valid, .out_res_re, .out_res_im, .out_overflow, .out_divide_by_zero
  );

  always #4 clk = ~clk;

  // Clamp a wide signed value into W bits; flag when clamped.
  function automatic logic [W-1:0] clamp_part(input logic signed [127:0] v, inout logic ovf);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (W - 1)) - 1;
    lo = -(128'sd1 <<< (W - 1));
    if (v > hi) begin
      ovf = 1'b1;
      return hi[W-1:0];
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo[W-1:0];
    end
    return v[W-1:0];
  endfunction

  // Truncate-toward-zero scaled quotient; sign carried separately.
  function automatic logic signed [127:0] scaled_quotient(input logic signed [127:0] num,
                                                          input logic signed [127:0] den);
    logic signed [127:0] mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< F) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [127:0] trunc_shift(input logic signed [127:0] v);
    logic signed [127:0] mag;
    mag = (v < 0) ? -v : v;
    mag = mag >>> F;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic complex_result_t predict_complex(input operand_set_t s);
    complex_result_t r;
    logic signed [127:0] ar, ai, br, bi, re, im, den;
    logic ovf;
    ar = $signed(s.a_re); ai = $signed(s.a_im);
    br = $signed(s.b_re); bi = $signed(s.b_im);
    re = 0; im = 0; ovf = 1'b0;
    r.dbz = 1'b0;
    case (s.op)
      OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      OP_MUL: begin
        re = trunc_shift(ar * br - ai * bi);
        im = trunc_shift(ai * br + ar * bi);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.dbz = 1'b1;
        else begin
          re = scaled_quotient(ar * br + ai * bi, den);
          im = scaled_quotient(br * ai - ar * bi, den);
        end
      end
      default: ;
    endcase
    r.re = clamp_part(re, ovf);
    r.im = clamp_part(im, ovf);
    r.ovf = ovf;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    $display("mismatch: result %0d field %s got %h expected %h", results_seen, what, got, want);
    mismatches++;
  endtask

  function automatic logic [W-1:0] rand_part();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(W-1){1'b1}}};
      1: return {1'b1, {(W-1){1'b0}}};
      2: return '0;
      3: return W'($signed($urandom_range(0, 1024)) - 512);
      default: return W'($urandom);
    endcase
  endfunction

  task automatic push_item(input op_t op, input logic [W-1:0] ar, ai, br, bi);
    operand_set_t s;
    s.op = op; s.a_re = ar; s.a_im = ai; s.b_re = br; s.b_im = bi;
    pending_q.push_back(s);
  endtask

  // Driver: hold start while a transfer is pending, insert random gaps.
  always @(posedge clk) begin
    operand_set_t s;
    if (rst_n) begin
      if (start && !busy) begin
        // transfer accepted at this edge: predict it now
        s.op = in_operation; s.a_re = in_a_re; s.a_im = in_a_im;
        s.b_re = in_b_re; s.b_im = in_b_im;
        expected_q.push_back(predict_complex(s));
        op_count[s.op]++;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_q.size() > 0) begin
          s = pending_q.pop_front();
          start <= 1'b1;
          in_operation <= s.op;
          in_a_re <= s.a_re; in_a_im <= s.a_im;
          in_b_re <= s.b_re; in_b_im <= s.b_im;
          case ($urandom_range(0, 19))
            0: gap_left <= $urandom_range(10, 40);
            1, 2, 3: gap_left <= $urandom_range(1, 3);
            default: gap_left <= 0;
          endcase
        end else start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result against the oldest prediction.
  always @(posedge clk) begin
    complex_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_res_re, '0);
      end else begin
        want = expected_q.pop_front();
        if (out_res_re !== want.re) report_mismatch("res_re", out_res_re, want.re);
        if (out_res_im !== want.im) report_mismatch("res_im", out_res_im, want.im);
        if (out_overflow !== want.ovf) report_mismatch("overflow", out_overflow, want.ovf);
        if (out_divide_by_zero !== want.dbz)
          report_mismatch("divide_by_zero", out_divide_by_zero, want.dbz);
        ovf_count += want.ovf;
        dbz_count += want.dbz;
      end
    end
  end

  // Watchdog: count cycles without any transfer on either side.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !stimulus_done) begin
      $display("watchdog expired");
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [W-1:0] maxv, minv, one;
    maxv = {1'b0, {(W-1){1'b1}}};
    minv = {1'b1, {(W-1){1'b0}}};
    one = W'(1) << F;
    // Directed: extremes, every operation, zero divisor, unused code.
    push_item(OP_ADD, maxv, minv, maxv, minv);
    push_item(OP_ADD, minv, maxv, '1, 1);
    push_item(OP_ADD, one, one, -one, -one);
    push_item(OP_MUL, maxv, maxv, maxv, maxv);
    push_item(OP_MUL, minv, minv, minv, minv);
    push_item(OP_MUL, minv, maxv, maxv, minv);
    push_item(OP_MUL, one, one, one, -one);
    push_item(OP_MUL, '1, 0, 1, 0);
    push_item(OP_DIV, one, one, 0, 0);
    push_item(OP_DIV, 0, 0, 0, 0);
    push_item(OP_DIV, maxv, maxv, 1, 0);
    push_item(OP_DIV, minv, minv, '1, '1);
    push_item(OP_DIV, minv, maxv, minv, minv);
    push_item(OP_DIV, one, 0, 0, one);
    push_item(OP_DIV, -one, one, 3, 0);
    push_item(OP_DIV, 1, 1, maxv, maxv);
    push_item(OP_UNUSED, maxv, minv, one, one);
    push_item(OP_UNUSED, 0, 0, 0, 0);
    repeat (1500)
      push_item(op_t'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2)),
                rand_part(), rand_part(), rand_part(), rand_part());

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() == 0 && gap_left == 0);
    @(posedge clk);
    wait (expected_q.size() == 0);
    stimulus_done = 1'b1;
    repeat (LATENCY + 5) @(posedge clk);
    $display("covered %0d add, %0d multiply, %0d divide, %0d unused-code items",
             op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("%0d results checked, %0d saturated, %0d zero divisors",
             results_seen, ovf_count, dbz_count);
    if (mismatches == 0 && expected_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

### filelist.f
rtl/core/cad_pkg.sv
rtl/core/complex_add_multiply_divide.sv
rtl/core/cad_checker.sv
sim/tb.sv
